// ===== rtl/core/flc_pkg.sv =====
// ----------------------------------------------------------------------------
// flc_pkg
// Shared constants, codes and types of the linear convolution FIR block.
// ----------------------------------------------------------------------------
package flc_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int SAMPLE_BITS = 16;
  localparam int Y_BITS      = 37;
  localparam int COEF_W      = 5;
  localparam int CFG_W       = 6;

  localparam logic [CFG_W-1:0] NUM_TAPS_RESET = 6'd32;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PUSH,
    S_SHIFT
  } state_t;

endpackage

// ===== rtl/core/flc_in_if.sv =====
// ----------------------------------------------------------------------------
// flc_in_if
// Input channel: coefficient loads and samples, valid/ready handshake.
// ----------------------------------------------------------------------------
interface flc_in_if #(
  parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS
);
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [flc_pkg::COEF_W-1:0]     coef_index;
  logic signed [SAMPLE_BITS-1:0]  value;
  logic                           last_sample;

  modport source (output valid, req_type, coef_index, value, last_sample, input ready);
  modport sink   (input valid, req_type, coef_index, value, last_sample, output ready);
endinterface

// ===== rtl/core/flc_out_if.sv =====
// ----------------------------------------------------------------------------
// flc_out_if
// Result channel: convolution outputs, valid/ready handshake.
// ----------------------------------------------------------------------------
interface flc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [flc_pkg::Y_BITS-1:0]  y;
  logic                               last_out;

  modport source (output valid, y, last_out, input ready);
  modport sink   (input valid, y, last_out, output ready);
endinterface

// ===== rtl/core/flc_ram.sv =====
// ----------------------------------------------------------------------------
// flc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module flc_ram #(
  parameter int WIDTH = flc_pkg::SAMPLE_BITS,
  parameter int DEPTH = flc_pkg::MAX_TAPS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fir_linear_convolution.sv =====
// ----------------------------------------------------------------------------
// fir_linear_convolution
// Streaming FIR filter giving the full linear convolution of a signal.
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries two kinds of transaction. a load (req_type = 0) writes one
//   coefficient into the tap RAM. a sample (req_type = 1)
//   enters the history RAM and gives one result on out_ch; a sample with
//   last_sample set also gives num_taps-1 tail results (zeros shifted in),
//   the final one flagged by last_out, after which the history is cleared.
//   cfg_we/cfg_wdata write num_taps, only while the block is idle; this is a
//   rule for the user, the block itself does not enforce it.
// result sequence:
//   each result writes the history RAM, then passes every tap through the
//   shared multiply-accumulate (one tap RAM and one history RAM read a
//   cycle), then its pipeline registers, and then loads the output register.
// reset:
//   rst_n is synchronous; num_taps returns to 32 and the history reads as
//   zero (per-entry valid bits). coefficients must be loaded before use.
// stall:
//   a result waits in the output register while in_ch is accepted again; the
//   next result is held back until out_ch takes the waiting one.
// ----------------------------------------------------------------------------
module fir_linear_convolution #(
  parameter int MAX_TAPS    = flc_pkg::MAX_TAPS,
  parameter int SAMPLE_BITS = flc_pkg::SAMPLE_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  flc_in_if.sink                    in_ch,
  flc_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [flc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int AW     = $clog2(MAX_TAPS);
  localparam int CNT_W  = $clog2(MAX_TAPS + 1);
  localparam int CMP_W  = (CNT_W > flc_pkg::CFG_W) ? CNT_W : flc_pkg::CFG_W;
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int YW     = flc_pkg::Y_BITS;

  flc_pkg::state_t state_r, state_nxt;

  logic [flc_pkg::CFG_W-1:0] num_taps_r;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [AW-1:0]             rp_r, rp_nxt;
  logic [AW-1:0]             j_r, j_nxt;
  logic [CNT_W-1:0]          taps_r, taps_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic                      last_r, last_nxt;
  logic [MAX_TAPS-1:0]       hist_vld_r, hist_vld_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [YW-1:0]      y_r;
  logic                      last_out_r;

  // multiply-accumulate pipeline
  logic                      s1_v_r, s1_first_r, s1_end_r, s1_hv_r;
  logic                      s2_v_r, s2_first_r, s2_end_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [YW-1:0]      acc_r;

  logic                      accept, issue, push, j_end;
  logic [AW-1:0]             wp_inc, rp_dec;
  logic [CMP_W-1:0]          nt_ext;
  logic [CNT_W-1:0]          taps_use;

  logic                      tap_we;
  logic [AW-1:0]             tap_waddr;
  logic [SAMPLE_BITS-1:0]    tap_rdata;
  logic                      hist_we;
  logic [AW-1:0]             hist_waddr;
  logic [SAMPLE_BITS-1:0]    hist_wdata;
  logic [SAMPLE_BITS-1:0]    hist_rdata;
  logic signed [SAMPLE_BITS-1:0] tap_s, hist_s;

  flc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (in_ch.value),
    .raddr (j_r),
    .rdata (tap_rdata)
  );

  flc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (rp_r),
    .rdata (hist_rdata)
  );

  // tap count clamped into 1..MAX_TAPS
  assign nt_ext   = CMP_W'(num_taps_r);
  assign taps_use = (nt_ext == '0) ? CNT_W'(1) :
                    (nt_ext > CMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(nt_ext);

  assign wp_inc = (wp_r == AW'(MAX_TAPS - 1)) ? '0 : wp_r + AW'(1);
  assign rp_dec = (rp_r == '0) ? AW'(MAX_TAPS - 1) : rp_r - AW'(1);
  assign j_end  = (CNT_W'(j_r) == taps_r - CNT_W'(1));

  assign in_ch.ready     = (state_r == flc_pkg::S_IDLE);
  assign accept          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.y        = y_r;
  assign out_ch.last_out = last_out_r;
  assign tap_waddr       = AW'(in_ch.coef_index);

  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    j_nxt        = j_r;
    taps_nxt     = taps_r;
    rem_nxt      = rem_r;
    last_nxt     = last_r;
    hist_vld_nxt = hist_vld_r;
    tap_we       = 1'b0;
    hist_we      = 1'b0;
    hist_waddr   = wp_inc;
    hist_wdata   = '0;
    issue        = 1'b0;
    push         = 1'b0;
    case (state_r)
      flc_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.req_type == flc_pkg::REQ_LOAD) begin
            tap_we = (32'(in_ch.coef_index) < MAX_TAPS);
          end else begin
            hist_we              = 1'b1;
            hist_wdata           = in_ch.value;
            hist_vld_nxt[wp_inc] = 1'b1;
            wp_nxt               = wp_inc;
            rp_nxt               = wp_inc;
            j_nxt                = '0;
            taps_nxt             = taps_use;
            rem_nxt              = in_ch.last_sample ? taps_use - CNT_W'(1) : '0;
            last_nxt             = in_ch.last_sample;
            state_nxt            = flc_pkg::S_READ;
          end
        end
      end
      flc_pkg::S_READ: begin
        issue  = 1'b1;
        rp_nxt = rp_dec;
        j_nxt  = j_r + AW'(1);
        if (j_end) begin
          state_nxt = flc_pkg::S_DRAIN;
        end
      end
      flc_pkg::S_DRAIN: begin
        if (s2_v_r && s2_end_r) begin
          state_nxt = flc_pkg::S_PUSH;
        end
      end
      flc_pkg::S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          push = 1'b1;
          if (rem_r != '0) begin
            rem_nxt   = rem_r - CNT_W'(1);
            state_nxt = flc_pkg::S_SHIFT;
          end else begin
            state_nxt = flc_pkg::S_IDLE;
            if (last_r) begin
              hist_vld_nxt = '0;
            end
          end
        end
      end
      flc_pkg::S_SHIFT: begin
        // tail: shift a zero into the history
        hist_we              = 1'b1;
        hist_wdata           = '0;
        hist_vld_nxt[wp_inc] = 1'b1;
        wp_nxt               = wp_inc;
        rp_nxt               = wp_inc;
        j_nxt                = '0;
        state_nxt            = flc_pkg::S_READ;
      end
      default: begin
        state_nxt = flc_pkg::S_IDLE;
      end
    endcase

    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flc_pkg::S_IDLE;
      num_taps_r  <= flc_pkg::NUM_TAPS_RESET;
      wp_r        <= '0;
      rp_r        <= '0;
      j_r         <= '0;
      taps_r      <= CNT_W'(1);
      rem_r       <= '0;
      last_r      <= 1'b0;
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      j_r         <= j_nxt;
      taps_r      <= taps_nxt;
      rem_r       <= rem_nxt;
      last_r      <= last_nxt;
      hist_vld_r  <= hist_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        num_taps_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      y_r        <= acc_r;
      last_out_r <= last_r && (rem_r == '0);
    end
  end

  assign tap_s  = tap_rdata;
  // history entries not yet written since the last clear read as zero
  assign hist_s = s1_hv_r ? hist_rdata : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
    end
    s1_first_r <= (j_r == '0);
    s1_end_r   <= j_end;
    s1_hv_r    <= hist_vld_r[rp_r];
    s2_first_r <= s1_first_r;
    s2_end_r   <= s1_end_r;
    p_r        <= tap_s * hist_s;
    if (s2_v_r) begin
      acc_r <= (s2_first_r ? '0 : acc_r) + YW'(p_r);
    end
  end

  a_end_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_end_r |-> state_r == flc_pkg::S_DRAIN)
    else $error("last product of a sum arrived outside the drain state");

  a_push_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == flc_pkg::S_PUSH |-> !s1_v_r && !s2_v_r)
    else $error("result pushed while products still in flight");

  a_tail_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != '0 |-> last_r)
    else $error("tail results pending on a sample not marked last");

  a_hist_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push && last_r && (rem_r == '0) |=> hist_vld_r == '0)
    else $error("history not cleared after the final result of a signal");

endmodule
